FILE: rtl/vqtm_pkg.sv
package vqtm_pkg;

    // Codebook geometry
    localparam int CODEBOOK_DEPTH   = 1024;
    localparam int CB_AW            = $clog2(CODEBOOK_DEPTH);
    localparam int TILE_WORDS       = 16;
    localparam int TILE_LINES       = 8;
    localparam int LINE_W           = 32;
    localparam int TILE_W           = TILE_LINES * LINE_W;

    // Frame limits
    localparam int MAX_TILES_DOWN   = 32;
    localparam int MAX_TILES_ACROSS = 40;

    // Reset values of the configuration registers
    localparam logic [5:0]  ACROSS_RESET  = 6'd40;
    localparam logic [5:0]  DOWN_RESET    = 6'd25;
    localparam logic [10:0] ENTRIES_RESET = 11'd1024;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_TILES_ACROSS     = 2'd0;
    localparam logic [1:0] REG_TILES_DOWN       = 2'd1;
    localparam logic [1:0] REG_CODEBOOK_ENTRIES = 2'd2;

    // Word kinds
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_MAP    = 1'b1;

    // Tile map parser phases
    typedef enum logic [1:0] {
        PH_HI,
        PH_LO,
        PH_IDX,
        PH_DONE
    } phase_t;

    // Codebook memory access from the parser
    typedef struct packed {
        logic              rd_en;
        logic [CB_AW-1:0]  rd_addr;
        logic              wr_en;
        logic [CB_AW-1:0]  wr_addr;
        logic [TILE_W-1:0] wr_data;
    } cb_req_t;

    // Position and status of a tile being decoded
    typedef struct packed {
        logic [5:0] col;
        logic [4:0] row;
        logic       bad;
    } tile_meta_t;

endpackage

FILE: rtl/vqtm_parser.sv
module vqtm_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    input  logic                  req_type,
    input  logic [15:0]           word,
    input  logic                  last_word,
    input  logic                  consume,
    input  logic [5:0]            tiles_across,
    input  logic [5:0]            tiles_down,
    input  logic [10:0]           codebook_entries,
    output logic                  emits,
    output vqtm_pkg::cb_req_t     cb_req,
    output vqtm_pkg::tile_meta_t  meta
);

    // Tile map parser state
    vqtm_pkg::phase_t phase_reg, phase_next;
    logic [31:0]      mask_reg, mask_next;
    logic [5:0]       col_reg, col_next;
    logic [4:0]       row_reg, row_next;

    // Update parser state
    logic [4:0]                  upd_cnt_reg, upd_cnt_next;
    logic [vqtm_pkg::CB_AW-1:0]  entry_reg, entry_next;
    logic [15:0]                 stage_reg [vqtm_pkg::TILE_WORDS-1];

    logic [5:0]        across_eff;
    logic [5:0]        down_eff;
    vqtm_pkg::phase_t  phase_eff;
    logic              is_map;
    logic [5:0]        scan_start;
    logic [31:0]       mask_full;
    logic [31:0]       cand;
    logic [31:0]       lowest;
    logic              found;
    logic [4:0]        row_found;
    logic [5:0]        col_plus;
    logic              upd_full;
    logic              stage_we;
    logic [3:0]        stage_idx;

    // Saturate the frame size registers
    assign across_eff = (tiles_across > 6'(vqtm_pkg::MAX_TILES_ACROSS)) ?
                        6'(vqtm_pkg::MAX_TILES_ACROSS) : tiles_across;
    assign down_eff   = (tiles_down > 6'(vqtm_pkg::MAX_TILES_DOWN)) ?
                        6'(vqtm_pkg::MAX_TILES_DOWN) : tiles_down;

    // A frame whose columns are used up ignores further map words
    assign phase_eff = (phase_reg != vqtm_pkg::PH_DONE && col_reg >= across_eff) ?
                       vqtm_pkg::PH_DONE : phase_reg;
    assign is_map    = (req_type == vqtm_pkg::REQ_MAP);
    assign col_plus  = col_reg + 6'd1;

    // Mask with the low word merged in while it is being read
    assign mask_full  = (phase_eff == vqtm_pkg::PH_LO) ? {mask_reg[31:16], word} : mask_reg;
    assign scan_start = {1'b0, row_reg} + ((phase_eff == vqtm_pkg::PH_IDX) ? 6'd1 : 6'd0);

    // Find the next row at or after the scan start whose mask bit is clear
    always_comb
    begin
        for (int r = 0; r < 32; r++)
        begin
            cand[r] = ~mask_full[31 - r] && (6'(r) >= scan_start) && (6'(r) < down_eff);
        end
    end

    assign lowest = cand & (~cand + 32'd1);
    assign found  = |cand;

    always_comb
    begin
        row_found = 5'd0;
        for (int r = 0; r < 32; r++)
        begin
            if (lowest[r])
            begin
                row_found = row_found | 5'(r);
            end
        end
    end

    // Update entry bookkeeping
    assign upd_full  = (upd_cnt_reg == 5'(vqtm_pkg::TILE_WORDS));
    assign stage_idx = upd_cnt_reg[3:0] - 4'd1;
    assign stage_we  = consume && !is_map && upd_cnt_reg != 5'd0 && !upd_full;

    // Next state of both parsers
    always_comb
    begin
        phase_next   = phase_reg;
        mask_next    = mask_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        upd_cnt_next = upd_cnt_reg;
        entry_next   = entry_reg;

        if (consume)
        begin
            if (is_map)
            begin
                phase_next = phase_eff;
                case (phase_eff)
                    vqtm_pkg::PH_HI:
                    begin
                        mask_next  = {word, 16'h0000};
                        phase_next = vqtm_pkg::PH_LO;
                    end
                    vqtm_pkg::PH_LO, vqtm_pkg::PH_IDX:
                    begin
                        mask_next = mask_full;
                        if (found)
                        begin
                            row_next   = row_found;
                            phase_next = vqtm_pkg::PH_IDX;
                        end
                        else
                        begin
                            row_next   = 5'd0;
                            col_next   = col_plus;
                            phase_next = (col_plus >= across_eff) ?
                                         vqtm_pkg::PH_DONE : vqtm_pkg::PH_HI;
                        end
                    end
                    default:
                    begin
                        phase_next = vqtm_pkg::PH_DONE;
                    end
                endcase
            end
            else
            begin
                if (upd_cnt_reg == 5'd0)
                begin
                    entry_next   = word[vqtm_pkg::CB_AW-1:0];
                    upd_cnt_next = 5'd1;
                end
                else if (upd_full)
                begin
                    upd_cnt_next = 5'd0;
                end
                else
                begin
                    upd_cnt_next = upd_cnt_reg + 5'd1;
                end
            end

            // End of chunk: both parsers start over
            if (last_word)
            begin
                phase_next   = vqtm_pkg::PH_HI;
                col_next     = 6'd0;
                row_next     = 5'd0;
                upd_cnt_next = 5'd0;
                entry_next   = '0;
            end
        end
    end

    // Outputs toward the codebook and the emitter
    always_comb
    begin
        emits          = word_valid && is_map && (phase_eff == vqtm_pkg::PH_IDX);
        cb_req.rd_en   = consume && emits;
        cb_req.rd_addr = word[vqtm_pkg::CB_AW-1:0];
        cb_req.wr_en   = consume && !is_map && upd_full;
        cb_req.wr_addr = entry_reg;
        for (int i = 0; i < vqtm_pkg::TILE_WORDS; i++)
        begin
            if (i < vqtm_pkg::TILE_WORDS - 1)
            begin
                cb_req.wr_data[(i / 2) * vqtm_pkg::LINE_W + (1 - i % 2) * 16 +: 16] = stage_reg[i];
            end
            else
            begin
                cb_req.wr_data[(i / 2) * vqtm_pkg::LINE_W + (1 - i % 2) * 16 +: 16] = word;
            end
        end
        meta.col = col_reg;
        meta.row = row_reg;
        meta.bad = (word >= 16'(codebook_entries)) ||
                   ({1'b0, word} >= 17'(vqtm_pkg::CODEBOOK_DEPTH));
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= vqtm_pkg::PH_HI;
            mask_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            upd_cnt_reg <= '0;
            entry_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            mask_reg    <= mask_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            upd_cnt_reg <= upd_cnt_next;
            entry_reg   <= entry_next;
        end
    end

    // Stage update words until the entry is complete
    always_ff @(posedge clk)
    begin
        if (stage_we)
        begin
            stage_reg[stage_idx] <= word;
        end
    end

endmodule

FILE: rtl/vqtm_codebook.sv
module vqtm_codebook
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  vqtm_pkg::cb_req_t               cb_req,
    output logic [vqtm_pkg::TILE_W-1:0]     rd_data,
    output logic                            busy
);

    logic [vqtm_pkg::TILE_W-1:0] mem [vqtm_pkg::CODEBOOK_DEPTH];
    logic [vqtm_pkg::TILE_W-1:0] rd_data_reg;
    logic                        clr_active_reg;
    logic [vqtm_pkg::CB_AW-1:0]  clr_addr_reg;

    logic                        we;
    logic [vqtm_pkg::CB_AW-1:0]  wa;
    logic [vqtm_pkg::TILE_W-1:0] wd;

    // Clearing sweep owns the write port after reset
    assign we = clr_active_reg || cb_req.wr_en;
    assign wa = clr_active_reg ? clr_addr_reg : cb_req.wr_addr;
    assign wd = clr_active_reg ? '0 : cb_req.wr_data;

    // Sweep one tile row per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + vqtm_pkg::CB_AW'(1);
            if (clr_addr_reg == vqtm_pkg::CB_AW'(vqtm_pkg::CODEBOOK_DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Tile memory: one row write and one registered row read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cb_req.rd_en)
        begin
            rd_data_reg <= mem[cb_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

FILE: rtl/vqtm_emitter.sv
module vqtm_emitter
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  vqtm_pkg::tile_meta_t         meta,
    input  logic [vqtm_pkg::TILE_W-1:0]  rd_data,
    input  logic                         out_stall,
    output logic                         tile_free,
    output logic                         out_valid,
    output logic [5:0]                   tile_col,
    output logic [4:0]                   tile_row,
    output logic [2:0]                   line,
    output logic [31:0]                  pixels,
    output logic                         bad_index,
    output logic                         last
);

    logic                 tile_valid_reg;
    logic [2:0]           line_reg;
    vqtm_pkg::tile_meta_t meta_reg;

    logic                 out_valid_reg;
    logic [5:0]           tile_col_reg;
    logic [4:0]           tile_row_reg;
    logic [2:0]           line_out_reg;
    logic [31:0]          pixels_reg;
    logic                 bad_index_reg;
    logic                 last_reg;

    logic                 move;
    logic                 line_is_last;

    // Advance a line whenever the result register frees up
    assign move         = tile_valid_reg && (!out_valid_reg || !out_stall);
    assign line_is_last = (line_reg == 3'(vqtm_pkg::TILE_LINES - 1));
    assign tile_free    = !tile_valid_reg || (move && line_is_last);

    // Tile line buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_valid_reg <= 1'b0;
            line_reg       <= '0;
        end
        else if (load)
        begin
            tile_valid_reg <= 1'b1;
            line_reg       <= '0;
        end
        else if (move)
        begin
            line_reg <= line_reg + 3'd1;
            if (line_is_last)
            begin
                tile_valid_reg <= 1'b0;
            end
        end
    end

    // Hold tile position for its eight lines
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            meta_reg <= meta;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            tile_col_reg  <= meta_reg.col;
            tile_row_reg  <= meta_reg.row;
            line_out_reg  <= line_reg;
            pixels_reg    <= rd_data[line_reg * vqtm_pkg::LINE_W +: vqtm_pkg::LINE_W];
            bad_index_reg <= meta_reg.bad;
            last_reg      <= line_is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign tile_col  = tile_col_reg;
    assign tile_row  = tile_row_reg;
    assign line      = line_out_reg;
    assign pixels    = pixels_reg;
    assign bad_index = bad_index_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/vq_tile_map_decoder.sv
// Vector-quantization tile map decoder. Words enter on in_valid/in_stall;
// update words (req_type 0) build codebook entries from an address word and
// 16 data words, and map words (req_type 1) carry per-column skip masks and
// tile indices. Every input word that is not an index is taken back to back.
// An index word yields eight result words, one tile line per cycle while
// out_stall is low: the tile line buffer streams one 32-bit line a cycle
// from a single registered read of the 1024 x 256-bit codebook memory, and
// the next index word is held until the previous tile's eighth line leaves
// that buffer. After reset the codebook is cleared one tile per cycle;
// in_stall stays high until it is done, while the register port is usable
// at once.
module vq_tile_map_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [15:0] word,
    input  logic        last_word,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  tile_col,
    output logic [4:0]  tile_row,
    output logic [2:0]  line,
    output logic [31:0] pixels,
    output logic        bad_index,
    output logic        last
);

    logic [5:0]  tiles_across_reg;
    logic [5:0]  tiles_down_reg;
    logic [10:0] codebook_entries_reg;
    logic        cfg_write;
    logic [1:0]  reg_idx;

    logic        in_valid_reg;
    logic        in_req_type_reg;
    logic [15:0] in_word_reg;
    logic        in_last_word_reg;

    logic                  emits;
    logic                  consume;
    logic                  tile_free;
    logic                  cb_busy;
    vqtm_pkg::cb_req_t     cb_req;
    vqtm_pkg::tile_meta_t  meta;
    logic [vqtm_pkg::TILE_W-1:0] rd_data;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiles_across_reg     <= vqtm_pkg::ACROSS_RESET;
            tiles_down_reg       <= vqtm_pkg::DOWN_RESET;
            codebook_entries_reg <= vqtm_pkg::ENTRIES_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                vqtm_pkg::REG_TILES_ACROSS:     tiles_across_reg     <= pwdata[5:0];
                vqtm_pkg::REG_TILES_DOWN:       tiles_down_reg       <= pwdata[5:0];
                vqtm_pkg::REG_CODEBOOK_ENTRIES: codebook_entries_reg <= pwdata[10:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            vqtm_pkg::REG_TILES_ACROSS:     prdata = {26'd0, tiles_across_reg};
            vqtm_pkg::REG_TILES_DOWN:       prdata = {26'd0, tiles_down_reg};
            vqtm_pkg::REG_CODEBOOK_ENTRIES: prdata = {21'd0, codebook_entries_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    // Consume the held word unless it is an index and the tile buffer is full
    assign consume  = in_valid_reg && (!emits || tile_free);
    assign in_stall = cb_busy || (in_valid_reg && !consume);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_req_type_reg  <= req_type;
            in_word_reg      <= word;
            in_last_word_reg <= last_word;
        end
    end

    vqtm_parser u_parser
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .word_valid       (in_valid_reg),
        .req_type         (in_req_type_reg),
        .word             (in_word_reg),
        .last_word        (in_last_word_reg),
        .consume          (consume),
        .tiles_across     (tiles_across_reg),
        .tiles_down       (tiles_down_reg),
        .codebook_entries (codebook_entries_reg),
        .emits            (emits),
        .cb_req           (cb_req),
        .meta             (meta)
    );

    vqtm_codebook u_codebook
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cb_req  (cb_req),
        .rd_data (rd_data),
        .busy    (cb_busy)
    );

    vqtm_emitter u_emitter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cb_req.rd_en),
        .meta      (meta),
        .rd_data   (rd_data),
        .out_stall (out_stall),
        .tile_free (tile_free),
        .out_valid (out_valid),
        .tile_col  (tile_col),
        .tile_row  (tile_row),
        .line      (line),
        .pixels    (pixels),
        .bad_index (bad_index),
        .last      (last)
    );

endmodule

FILE: rtl/vqtm_checker.sv
module vqtm_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  tile_col,
    input  logic [4:0]  tile_row,
    input  logic [2:0]  line,
    input  logic [31:0] pixels,
    input  logic        bad_index,
    input  logic        last
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tile_col) && $stable(tile_row)
            && $stable(line) && $stable(pixels) && $stable(bad_index) && $stable(last))
        else $error("result word changed while stalled");

    // Last flag marks the bottom line of a tile
    a_last_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (line == 3'(vqtm_pkg::TILE_LINES - 1))))
        else $error("last flag does not match line number");

    // Column stays inside the widest frame
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tile_col < 6'(vqtm_pkg::MAX_TILES_ACROSS)))
        else $error("tile column out of range");

    // Lines of one tile follow each other without a gap
    a_line_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && (line == $past(line) + 3'd1)
            && (tile_col == $past(tile_col)) && (tile_row == $past(tile_row))
            && (bad_index == $past(bad_index)))
        else $error("tile lines not streamed in order");

endmodule

bind vq_tile_map_decoder vqtm_checker u_vqtm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tile_col  (tile_col),
    .tile_row  (tile_row),
    .line      (line),
    .pixels    (pixels),
    .bad_index (bad_index),
    .last      (last)
);
